// ----- rtl/core/mmcc_pkg.sv -----
// Shared widths, constants and controller/datapath link types for the magnetometer calibrator.
package mmcc_pkg;

    localparam int SCALE_FRAC_BITS = 12;

    localparam int AXES    = 3;
    localparam int AXIS_W  = 2;
    localparam int RAW_W   = 16;
    localparam int OFS_W   = 18;
    localparam int SPAN_W  = 18;
    localparam int SUM_W   = 20;
    localparam int DEN_W   = 18;
    localparam int REM_W   = DEN_W;
    localparam int GAIN_W  = 16;
    localparam int OUT_W   = 21;
    localparam int DIFF_W  = 19;
    localparam int PROD_W  = DIFF_W + GAIN_W + 1;
    localparam int NUM_W   = DEN_W + SCALE_FRAC_BITS;
    localparam int CMP_W   = DEN_W + GAIN_W;
    localparam int STEP_W  = $clog2(GAIN_W);

    localparam logic signed [RAW_W-1:0] MIN_INIT = 16'sd32767;
    localparam logic signed [RAW_W-1:0] MAX_INIT = -16'sd32767;

    localparam logic [GAIN_W-1:0] GAIN_MAX = '1;
    localparam int UNITY_INT = ((64'd1 << SCALE_FRAC_BITS) > 64'd65535) ?
                               65535 : (1 << SCALE_FRAC_BITS);
    localparam logic [GAIN_W-1:0] UNITY_GAIN = UNITY_INT[GAIN_W-1:0];

    localparam logic signed [PROD_W-1:0] OUT_HI =
        PROD_W'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
    localparam logic signed [PROD_W-1:0] OUT_LO = ~OUT_HI;

    typedef struct packed {
        logic              capture;
        logic              minmax;
        logic              prep;
        logic              sum;
        logic              div_init;
        logic              div_step;
        logic              div_end;
        logic              mul;
        logic              sat;
        logic              load_out;
        logic [AXIS_W-1:0] axis;
    } mmcc_cmd_t;

    typedef struct packed {
        logic last;
        logic div_special;
    } mmcc_stat_t;

endpackage

// ----- rtl/core/mmcc_in_if.sv -----
// Input channel interface carrying one raw three-axis sample per transaction.
interface mmcc_in_if;
    logic                                    valid;
    logic                                    ready;
    logic                                    mode;
    logic                                    last;
    logic signed [mmcc_pkg::RAW_W-1:0]       raw_x;
    logic signed [mmcc_pkg::RAW_W-1:0]       raw_y;
    logic signed [mmcc_pkg::RAW_W-1:0]       raw_z;

    modport source (output valid, mode, last, raw_x, raw_y, raw_z, input ready);
    modport sink   (input valid, mode, last, raw_x, raw_y, raw_z, output ready);
endinterface

// ----- rtl/core/mmcc_out_if.sv -----
// Output channel interface carrying one corrected sample or calibration result per transaction.
interface mmcc_out_if;
    logic                                    valid;
    logic                                    ready;
    logic                                    kind;
    logic signed [mmcc_pkg::OUT_W-1:0]       x_out;
    logic signed [mmcc_pkg::OUT_W-1:0]       y_out;
    logic signed [mmcc_pkg::OUT_W-1:0]       z_out;
    logic [mmcc_pkg::GAIN_W-1:0]             x_gain;
    logic [mmcc_pkg::GAIN_W-1:0]             y_gain;
    logic [mmcc_pkg::GAIN_W-1:0]             z_gain;
    logic                                    span_error;

    modport source (output valid, kind, x_out, y_out, z_out, x_gain, y_gain, z_gain,
                    span_error, input ready);
    modport sink   (input valid, kind, x_out, y_out, z_out, x_gain, y_gain, z_gain,
                    span_error, output ready);
endinterface

// ----- rtl/core/mmcc_datapath.sv -----
// Datapath: min/max tracking, offsets, iterative scale division, shared correction multiplier.
module mmcc_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  mmcc_pkg::mmcc_cmd_t                   cmd,
    input  logic                                  mode,
    input  logic                                  last,
    input  logic signed [mmcc_pkg::RAW_W-1:0]     raw_x,
    input  logic signed [mmcc_pkg::RAW_W-1:0]     raw_y,
    input  logic signed [mmcc_pkg::RAW_W-1:0]     raw_z,
    output mmcc_pkg::mmcc_stat_t                  stat,
    output logic                                  kind,
    output logic signed [mmcc_pkg::OUT_W-1:0]     x_out,
    output logic signed [mmcc_pkg::OUT_W-1:0]     y_out,
    output logic signed [mmcc_pkg::OUT_W-1:0]     z_out,
    output logic [mmcc_pkg::GAIN_W-1:0]           x_gain,
    output logic [mmcc_pkg::GAIN_W-1:0]           y_gain,
    output logic [mmcc_pkg::GAIN_W-1:0]           z_gain,
    output logic                                  span_error
);
    import mmcc_pkg::*;

    logic                     mode_reg;
    logic                     last_reg;
    logic signed [RAW_W-1:0]  raw_reg   [AXES];
    logic signed [RAW_W-1:0]  min_reg   [AXES];
    logic signed [RAW_W-1:0]  max_reg   [AXES];
    logic signed [OFS_W-1:0]  ofs_reg   [AXES];
    logic [GAIN_W-1:0]        scale_reg [AXES];
    logic signed [SPAN_W-1:0] span_reg  [AXES];
    logic signed [OUT_W-1:0]  res_reg   [AXES];
    logic signed [SUM_W-1:0]  sum_reg;
    logic                     err_reg;
    logic [DEN_W-1:0]         den_reg;
    logic [REM_W-1:0]         rem_reg;
    logic [GAIN_W-1:0]        quo_reg;
    logic [GAIN_W-1:0]        gain_reg;
    logic                     special_reg;
    logic signed [PROD_W-1:0] prod_reg;

    logic                     kind_reg;
    logic signed [OUT_W-1:0]  val_out_reg  [AXES];
    logic [GAIN_W-1:0]        gain_out_reg [AXES];
    logic                     err_out_reg;

    logic signed [SPAN_W-1:0] span_sel;
    logic [DEN_W-1:0]         den_calc;
    logic [NUM_W-1:0]         num_calc;
    logic                     ovf_calc;
    logic                     span_bad;
    logic                     sum_bad;
    logic                     special_calc;
    logic [GAIN_W-1:0]        gain_calc;
    logic [REM_W+1:0]         trial;
    logic                     take;
    logic signed [DIFF_W-1:0] diff_calc;
    logic signed [GAIN_W:0]   scale_s;
    logic signed [PROD_W-1:0] prod_calc;
    logic signed [PROD_W-1:0] shifted;
    logic signed [OUT_W-1:0]  sat_calc;

    assign span_sel = span_reg[cmd.axis];
    assign den_calc = DEN_W'(unsigned'(span_sel)) + DEN_W'({unsigned'(span_sel), 1'b0});
    assign num_calc = {sum_reg[DEN_W-1:0], {SCALE_FRAC_BITS{1'b0}}};
    assign ovf_calc = CMP_W'(num_calc) >= {den_calc, {GAIN_W{1'b0}}};
    assign span_bad = span_sel[SPAN_W-1] || (span_sel == '0);
    assign sum_bad  = sum_reg[SUM_W-1] || (sum_reg == '0);

    always_comb
    begin
        special_calc = 1'b1;
        gain_calc    = '0;
        priority if (span_bad)
        begin
            gain_calc = UNITY_GAIN;
        end
        else if (sum_bad)
        begin
            gain_calc = '0;
        end
        else if (ovf_calc)
        begin
            gain_calc = GAIN_MAX;
        end
        else
        begin
            special_calc = 1'b0;
        end
    end

    assign trial = {1'b0, rem_reg, quo_reg[GAIN_W-1]} - {2'b00, den_reg};
    assign take  = !trial[REM_W+1];

    assign diff_calc = {{2{raw_reg[cmd.axis][RAW_W-1]}}, raw_reg[cmd.axis], 1'b0}
                     - {ofs_reg[cmd.axis][OFS_W-1], ofs_reg[cmd.axis]};
    assign scale_s   = {1'b0, scale_reg[cmd.axis]};
    assign prod_calc = diff_calc * scale_s;
    assign shifted   = prod_reg >>> (SCALE_FRAC_BITS + 1);

    always_comb
    begin
        priority if (shifted > OUT_HI)
        begin
            sat_calc = OUT_HI[OUT_W-1:0];
        end
        else if (shifted < OUT_LO)
        begin
            sat_calc = OUT_LO[OUT_W-1:0];
        end
        else
        begin
            sat_calc = shifted[OUT_W-1:0];
        end
    end

    assign stat.last        = last_reg;
    assign stat.div_special = special_calc;

    // Calibration state with defined reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                min_reg[i]   <= MIN_INIT;
                max_reg[i]   <= MAX_INIT;
                ofs_reg[i]   <= '0;
                scale_reg[i] <= UNITY_GAIN;
            end
            err_reg <= 1'b0;
        end
        else
        begin
            if (cmd.minmax)
            begin
                for (int i = 0; i < AXES; i++)
                begin
                    if (raw_reg[i] < min_reg[i])
                    begin
                        min_reg[i] <= raw_reg[i];
                    end
                    if (raw_reg[i] > max_reg[i])
                    begin
                        max_reg[i] <= raw_reg[i];
                    end
                end
            end
            if (cmd.prep)
            begin
                for (int i = 0; i < AXES; i++)
                begin
                    ofs_reg[i] <= {{2{max_reg[i][RAW_W-1]}}, max_reg[i]}
                                + {{2{min_reg[i][RAW_W-1]}}, min_reg[i]};
                    min_reg[i] <= MIN_INIT;
                    max_reg[i] <= MAX_INIT;
                end
                err_reg <= 1'b0;
            end
            if (cmd.div_init && span_bad)
            begin
                err_reg <= 1'b1;
            end
            if (cmd.div_end)
            begin
                scale_reg[cmd.axis] <= special_reg ? gain_reg : quo_reg;
            end
        end
    end

    // Working and output payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg   <= mode;
            last_reg   <= last;
            raw_reg[0] <= raw_x;
            raw_reg[1] <= raw_y;
            raw_reg[2] <= raw_z;
        end
        if (cmd.prep)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                span_reg[i] <= {{2{max_reg[i][RAW_W-1]}}, max_reg[i]}
                             - {{2{min_reg[i][RAW_W-1]}}, min_reg[i]};
            end
        end
        if (cmd.sum)
        begin
            sum_reg <= SUM_W'(span_reg[0]) + SUM_W'(span_reg[1]) + SUM_W'(span_reg[2]);
        end
        if (cmd.div_init)
        begin
            den_reg     <= den_calc;
            rem_reg     <= REM_W'(num_calc >> GAIN_W);
            quo_reg     <= num_calc[GAIN_W-1:0];
            gain_reg    <= gain_calc;
            special_reg <= special_calc;
        end
        if (cmd.div_step)
        begin
            rem_reg <= take ? trial[REM_W-1:0] : {rem_reg[REM_W-2:0], quo_reg[GAIN_W-1]};
            quo_reg <= {quo_reg[GAIN_W-2:0], take};
        end
        if (cmd.mul)
        begin
            prod_reg <= prod_calc;
        end
        if (cmd.sat)
        begin
            res_reg[cmd.axis] <= sat_calc;
        end
        if (cmd.load_out)
        begin
            kind_reg    <= !mode_reg;
            err_out_reg <= mode_reg ? 1'b0 : err_reg;
            for (int i = 0; i < AXES; i++)
            begin
                val_out_reg[i]  <= mode_reg ? res_reg[i] : OUT_W'(ofs_reg[i]);
                gain_out_reg[i] <= mode_reg ? '0 : scale_reg[i];
            end
        end
    end

    assign kind       = kind_reg;
    assign x_out      = val_out_reg[0];
    assign y_out      = val_out_reg[1];
    assign z_out      = val_out_reg[2];
    assign x_gain     = gain_out_reg[0];
    assign y_gain     = gain_out_reg[1];
    assign z_gain     = gain_out_reg[2];
    assign span_error = err_out_reg;

endmodule

// ----- rtl/core/mmcc_ctrl.sv -----
// Controller state machine sequencing capture, calibration, division and correction.
module mmcc_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_mode,
    input  logic                  out_ready,
    input  mmcc_pkg::mmcc_stat_t  stat,
    output logic                  in_ready,
    output logic                  out_valid,
    output mmcc_pkg::mmcc_cmd_t   cmd
);
    import mmcc_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE     = 10'b0000000001,
        S_MINMAX   = 10'b0000000010,
        S_PREP     = 10'b0000000100,
        S_SUM      = 10'b0000001000,
        S_DIV_INIT = 10'b0000010000,
        S_DIV      = 10'b0000100000,
        S_DIV_END  = 10'b0001000000,
        S_MUL      = 10'b0010000000,
        S_SAT      = 10'b0100000000,
        S_EMIT     = 10'b1000000000
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [AXIS_W-1:0]   axis_reg;
    logic [AXIS_W-1:0]   axis_next;
    logic [STEP_W-1:0]   step_reg;
    logic [STEP_W-1:0]   step_next;
    logic                out_valid_reg;
    logic                out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.axis   = axis_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    axis_next   = '0;
                    state_next  = in_mode ? S_MUL : S_MINMAX;
                end
            end
            S_MINMAX:
            begin
                cmd.minmax = 1'b1;
                state_next = stat.last ? S_PREP : S_IDLE;
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum    = 1'b1;
                axis_next  = '0;
                state_next = S_DIV_INIT;
            end
            S_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                step_next    = '0;
                state_next   = stat.div_special ? S_DIV_END : S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(GAIN_W - 1))
                begin
                    state_next = S_DIV_END;
                end
            end
            S_DIV_END:
            begin
                cmd.div_end = 1'b1;
                if (axis_reg == AXIS_W'(AXES - 1))
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    axis_next  = axis_reg + AXIS_W'(1);
                    state_next = S_DIV_INIT;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_SAT;
            end
            S_SAT:
            begin
                cmd.sat = 1'b1;
                if (axis_reg == AXIS_W'(AXES - 1))
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    axis_next  = axis_reg + AXIS_W'(1);
                    state_next = S_MUL;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            axis_reg      <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- rtl/core/magnetometer_minmax_calibrate_correct.sv -----
// Top level of the three-axis magnetometer min/max calibrator and sample corrector.
//
//   Channel   Direction   Transaction
//   sample    in          mode, last, raw_x, raw_y, raw_z
//   result    out         kind, x_out/y_out/z_out, x_gain/y_gain/z_gain, span_error
//
// A calibration sample without last only updates min/max; for a corrected sample the
// single multiplier is shared by the three axes, each taking a multiply and a saturate step.
// On a final calibration sample the shared restoring divider yields one quotient bit per
// cycle, and an axis whose scale is fixed by a bad span, a bad sum or saturation skips
// its division steps.
// Reset clears min/max to their rearmed values, offsets to zero and scales to unity.
// The result sits in an output register, so the next sample is accepted while it waits.
module magnetometer_minmax_calibrate_correct (
    input  logic          clk,
    input  logic          rst_n,
    mmcc_in_if.sink       sample,
    mmcc_out_if.source    result
);
    import mmcc_pkg::*;

    mmcc_cmd_t  cmd;
    mmcc_stat_t stat;
    logic       in_ready;
    logic       out_valid;

    mmcc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_mode   (sample.mode),
        .out_ready (result.ready),
        .stat      (stat),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    mmcc_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .mode       (sample.mode),
        .last       (sample.last),
        .raw_x      (sample.raw_x),
        .raw_y      (sample.raw_y),
        .raw_z      (sample.raw_z),
        .stat       (stat),
        .kind       (result.kind),
        .x_out      (result.x_out),
        .y_out      (result.y_out),
        .z_out      (result.z_out),
        .x_gain     (result.x_gain),
        .y_gain     (result.y_gain),
        .z_gain     (result.z_gain),
        .span_error (result.span_error)
    );

    assign sample.ready = in_ready;
    assign result.valid = out_valid;

endmodule

// ----- rtl/core/mmcc_checker.sv -----
// Port-level checker for the magnetometer calibrator, bound to the top level.
module mmcc_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                in_mode,
    input logic                                in_last,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic                                kind,
    input logic signed [mmcc_pkg::OUT_W-1:0]   x_out,
    input logic [mmcc_pkg::GAIN_W-1:0]         x_gain,
    input logic [mmcc_pkg::GAIN_W-1:0]         y_gain,
    input logic [mmcc_pkg::GAIN_W-1:0]         z_gain,
    input logic                                span_error
);
    import mmcc_pkg::*;

    logic in_fire;
    assign in_fire = in_valid && in_ready;

    // The block works on one transaction at a time.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !in_ready)
        else $error("input accepted again right after a transaction");

    // A calibration sample that does not finish returns to idle after its min/max update.
    a_cal_sample_turnaround: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !in_mode && !in_last) |-> ##2 in_ready)
        else $error("calibration sample did not return to idle in two cycles");

    // A corrected sample carries no scales and no span error.
    a_corrected_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !kind) |->
            (x_gain == '0 && y_gain == '0 && z_gain == '0 && !span_error))
        else $error("corrected sample carries calibration fields");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result withdrawn before it was taken");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            ($stable(kind) && $stable(x_out) && $stable(x_gain) && $stable(span_error)))
        else $error("stalled result changed");

endmodule

bind magnetometer_minmax_calibrate_correct mmcc_checker u_mmcc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (sample.valid),
    .in_ready   (sample.ready),
    .in_mode    (sample.mode),
    .in_last    (sample.last),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .kind       (result.kind),
    .x_out      (result.x_out),
    .x_gain     (result.x_gain),
    .y_gain     (result.y_gain),
    .z_gain     (result.z_gain),
    .span_error (result.span_error)
);

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the magnetometer min/max calibrator and sample corrector.
module testbench;
    import mmcc_pkg::*;

    localparam logic MODE_CAL     = 1'b0;
    localparam logic MODE_CORRECT = 1'b1;
    localparam logic KIND_SAMPLE  = 1'b0;
    localparam logic KIND_CAL     = 1'b1;

    localparam int ITEMS      = 1300;
    localparam int MAX_WAIT   = 16;
    localparam int HOLD_AT    = 200;
    localparam int HOLD_LEN   = 300;
    localparam int DRAIN      = 64;
    localparam int IDLE_LIMIT = 2000;

    localparam longint OUT_MAX  = (longint'(1) <<< (OUT_W - 1)) - 1;
    localparam longint OUT_MIN  = -OUT_MAX - 1;
    localparam longint GAIN_CAP = (longint'(1) << GAIN_W) - 1;
    localparam logic [GAIN_W-1:0] UNITY =
        ((64'd1 << SCALE_FRAC_BITS) > 64'd65535) ? 16'hFFFF : GAIN_W'(1 << SCALE_FRAC_BITS);

    typedef enum int {SPREAD_FULL, SPREAD_CLUSTER, SPREAD_RAIL, SPREAD_FLAT} spread_t;

    typedef struct packed {
        logic                    kind;
        logic signed [OUT_W-1:0] x_out;
        logic signed [OUT_W-1:0] y_out;
        logic signed [OUT_W-1:0] z_out;
        logic [GAIN_W-1:0]       x_gain;
        logic [GAIN_W-1:0]       y_gain;
        logic [GAIN_W-1:0]       z_gain;
        logic                    span_error;
    } mag_result_t;

    typedef struct packed {
        logic                    mode;
        logic                    last;
        logic signed [RAW_W-1:0] rx;
        logic signed [RAW_W-1:0] ry;
        logic signed [RAW_W-1:0] rz;
        logic                    typed;
        mag_result_t             res;
    } stim_row_t;

    logic clk;
    logic rst_n;

    mmcc_in_if  sample_if();
    mmcc_out_if result_if();

    magnetometer_minmax_calibrate_correct u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_if),
        .result (result_if)
    );

    logic signed [RAW_W-1:0] axis_lo [3];
    logic signed [RAW_W-1:0] axis_hi [3];
    logic signed [OFS_W-1:0] centre_half [3];
    logic [GAIN_W-1:0]       axis_gain [3];

    mag_result_t expected_q [$];
    stim_row_t   directed_rows [$];
    int          mismatches = 0;
    int          items_sent = 0;
    int          idle_cycles = 0;
    bit          tx_calm = 1'b0;
    bit          rx_calm = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void rearm_extremes();
        for (int i = 0; i < 3; i++)
        begin
            axis_lo[i] = 16'sh7FFF;
            axis_hi[i] = -16'sh7FFF;
        end
    endfunction

    function automatic bit calibrate_or_correct(input logic mode, input logic last,
                                                input logic signed [RAW_W-1:0] rx,
                                                input logic signed [RAW_W-1:0] ry,
                                                input logic signed [RAW_W-1:0] rz,
                                                output mag_result_t res);
        logic signed [RAW_W-1:0] raw [3];
        logic signed [OUT_W-1:0] axis_val [3];
        longint                  span [3];
        longint                  span_sum;
        longint                  prod;
        longint                  quo;
        bit                      bad_span;
        raw[0] = rx;
        raw[1] = ry;
        raw[2] = rz;
        res = '0;
        if (mode == MODE_CORRECT)
        begin
            for (int i = 0; i < 3; i++)
            begin
                prod = (2 * longint'(raw[i]) - longint'(centre_half[i])) * longint'(axis_gain[i]);
                quo = prod >>> (SCALE_FRAC_BITS + 1);
                if (quo > OUT_MAX)
                    quo = OUT_MAX;
                if (quo < OUT_MIN)
                    quo = OUT_MIN;
                axis_val[i] = quo[OUT_W-1:0];
            end
            res.kind  = KIND_SAMPLE;
            res.x_out = axis_val[0];
            res.y_out = axis_val[1];
            res.z_out = axis_val[2];
            return 1'b1;
        end
        for (int i = 0; i < 3; i++)
        begin
            if (raw[i] < axis_lo[i])
                axis_lo[i] = raw[i];
            if (raw[i] > axis_hi[i])
                axis_hi[i] = raw[i];
        end
        if (!last)
            return 1'b0;
        span_sum = 0;
        bad_span = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            centre_half[i] = axis_hi[i] + axis_lo[i];
            span[i] = longint'(axis_hi[i]) - longint'(axis_lo[i]);
            span_sum += span[i];
        end
        for (int i = 0; i < 3; i++)
        begin
            if (span[i] <= 0)
            begin
                bad_span = 1'b1;
                axis_gain[i] = UNITY;
            end
            else if (span_sum <= 0)
                axis_gain[i] = '0;
            else
            begin
                quo = (span_sum <<< SCALE_FRAC_BITS) / (3 * span[i]);
                axis_gain[i] = (quo > GAIN_CAP) ? GAIN_CAP[GAIN_W-1:0] : quo[GAIN_W-1:0];
            end
        end
        res.kind       = KIND_CAL;
        res.x_out      = centre_half[0];
        res.y_out      = centre_half[1];
        res.z_out      = centre_half[2];
        res.x_gain     = axis_gain[0];
        res.y_gain     = axis_gain[1];
        res.z_gain     = axis_gain[2];
        res.span_error = bad_span;
        rearm_extremes();
        return 1'b1;
    endfunction

    function automatic logic signed [RAW_W-1:0] draw_axis(input spread_t how, input int centre,
                                                           input int radius);
        int v;
        case (how)
            SPREAD_FULL:    v = int'($urandom_range(0, 65535)) - 32768;
            SPREAD_CLUSTER: v = centre + int'($urandom_range(0, 2 * radius)) - radius;
            SPREAD_RAIL:    v = $urandom_range(0, 1) ? 32767 : -32768;
            default:        v = centre;
        endcase
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return RAW_W'(v);
    endfunction

    task automatic offer(input stim_row_t row);
        int          gap;
        mag_result_t res;
        if (items_sent % 96 == 0)
            tx_calm = ($urandom_range(0, 3) == 0);
        gap = tx_calm ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            sample_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_if.valid <= 1'b1;
        sample_if.mode  <= row.mode;
        sample_if.last  <= row.last;
        sample_if.raw_x <= row.rx;
        sample_if.raw_y <= row.ry;
        sample_if.raw_z <= row.rz;
        do @(posedge clk); while (!sample_if.ready);
        if (calibrate_or_correct(row.mode, row.last, row.rx, row.ry, row.rz, res))
            expected_q.push_back(row.typed ? row.res : res);
        items_sent++;
    endtask

    task automatic offer_raw(input logic mode, input logic last,
                             input logic signed [RAW_W-1:0] rx,
                             input logic signed [RAW_W-1:0] ry,
                             input logic signed [RAW_W-1:0] rz);
        stim_row_t row;
        row = '0;
        row.mode = mode;
        row.last = last;
        row.rx = rx;
        row.ry = ry;
        row.rz = rz;
        offer(row);
    endtask

    task automatic row_pred(input logic mode, input logic last, input int rx, input int ry,
                            input int rz);
        stim_row_t row;
        row = '0;
        row.mode = mode;
        row.last = last;
        row.rx = RAW_W'(rx);
        row.ry = RAW_W'(ry);
        row.rz = RAW_W'(rz);
        directed_rows.push_back(row);
    endtask

    task automatic row_typed(input logic mode, input logic last, input int rx, input int ry,
                             input int rz, input logic kind, input int xo, input int yo,
                             input int zo, input logic [GAIN_W-1:0] gain, input logic err);
        stim_row_t row;
        row = '0;
        row.mode = mode;
        row.last = last;
        row.rx = RAW_W'(rx);
        row.ry = RAW_W'(ry);
        row.rz = RAW_W'(rz);
        row.typed = 1'b1;
        row.res.kind = kind;
        row.res.x_out = OUT_W'(xo);
        row.res.y_out = OUT_W'(yo);
        row.res.z_out = OUT_W'(zo);
        row.res.x_gain = gain;
        row.res.y_gain = gain;
        row.res.z_gain = gain;
        row.res.span_error = err;
        directed_rows.push_back(row);
    endtask

    task automatic check_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    initial
    begin
        spread_t how [3];
        int      centre [3];
        int      radius [3];
        int      run_len;
        sample_if.valid <= 1'b0;
        sample_if.mode  <= MODE_CAL;
        sample_if.last  <= 1'b0;
        sample_if.raw_x <= '0;
        sample_if.raw_y <= '0;
        sample_if.raw_z <= '0;
        rst_n <= 1'b0;
        rearm_extremes();
        for (int i = 0; i < 3; i++)
        begin
            centre_half[i] = '0;
            axis_gain[i] = UNITY;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        row_typed(MODE_CORRECT, 1'b0, 32767, -32768, 0, KIND_SAMPLE, 32767, -32768, 0, '0, 1'b0);
        row_typed(MODE_CORRECT, 1'b1, -1, 1, 12345, KIND_SAMPLE, -1, 1, 12345, '0, 1'b0);
        row_typed(MODE_CAL, 1'b1, 1, 2, 3, KIND_CAL, 2, 4, 6, UNITY, 1'b1);
        row_typed(MODE_CORRECT, 1'b0, 1, 2, 3, KIND_SAMPLE, 0, 0, 0, '0, 1'b0);
        row_pred(MODE_CAL, 1'b0, -32768, -32768, -32768);
        row_typed(MODE_CAL, 1'b1, 32767, 32767, 32767, KIND_CAL, -1, -1, -1, UNITY, 1'b0);
        row_pred(MODE_CORRECT, 1'b0, 32767, -32768, 0);
        row_typed(MODE_CAL, 1'b1, -32768, -32768, -32768, KIND_CAL, -65535, -65535, -65535,
                  UNITY, 1'b0);
        row_pred(MODE_CORRECT, 1'b0, 32767, 32767, 32767);
        row_pred(MODE_CORRECT, 1'b0, -32768, -32768, -32768);
        row_pred(MODE_CAL, 1'b0, -32768, 0, 0);
        row_pred(MODE_CAL, 1'b1, 32767, 1, 1);
        row_pred(MODE_CORRECT, 1'b0, -32768, -32768, 32767);
        row_pred(MODE_CORRECT, 1'b0, 32767, 32767, -32768);
        row_pred(MODE_CAL, 1'b0, 5, -100, 7);
        row_pred(MODE_CAL, 1'b1, 5, 100, 7);
        row_pred(MODE_CORRECT, 1'b0, -12345, 54, 7);
        row_pred(MODE_CAL, 1'b0, 0, 0, 0);
        row_pred(MODE_CORRECT, 1'b1, 30000, -30000, 30000);
        row_pred(MODE_CAL, 1'b1, 10, 10, 10);
        row_pred(MODE_CORRECT, 1'b0, -1, -1, -1);
        row_typed(MODE_CAL, 1'b1, 32767, 32767, 32767, KIND_CAL, 65534, 65534, 65534,
                  UNITY, 1'b1);
        row_pred(MODE_CORRECT, 1'b0, -32768, -32768, -32768);
        row_pred(MODE_CORRECT, 1'b0, 32767, 32767, 32767);
        foreach (directed_rows[i])
            offer(directed_rows[i]);

        // Most traffic is a calibration run closed by last, followed by samples to correct.
        while (items_sent < ITEMS)
        begin
            for (int i = 0; i < 3; i++)
            begin
                how[i] = spread_t'($urandom_range(0, 3));
                centre[i] = int'($urandom_range(0, 65535)) - 32768;
                radius[i] = $urandom_range(0, 1) ? $urandom_range(0, 64) : $urandom_range(0, 8000);
            end
            if ($urandom_range(0, 9) < 8)
            begin
                run_len = $urandom_range(1, 30);
                for (int k = 0; k < run_len; k++)
                    offer_raw(MODE_CAL, k == run_len - 1, draw_axis(how[0], centre[0], radius[0]),
                              draw_axis(how[1], centre[1], radius[1]),
                              draw_axis(how[2], centre[2], radius[2]));
                run_len = $urandom_range(1, 20);
                for (int k = 0; k < run_len; k++)
                    offer_raw(MODE_CORRECT, $urandom_range(0, 7) == 0,
                              draw_axis(how[0], centre[0], radius[0]),
                              draw_axis(how[1], centre[1], radius[1]),
                              draw_axis(how[2], centre[2], radius[2]));
            end
            else
            begin
                run_len = $urandom_range(1, 10);
                for (int k = 0; k < run_len; k++)
                    offer_raw(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              draw_axis(SPREAD_FULL, 0, 0), draw_axis(SPREAD_FULL, 0, 0),
                              draw_axis(SPREAD_FULL, 0, 0));
            end
        end
        sample_if.valid <= 1'b0;

        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        int gap;
        int taken;
        bit held;
        taken = 0;
        held = 1'b0;
        result_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (taken == HOLD_AT && !held)
            begin
                held = 1'b1;
                result_if.ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge clk);
            end
            if (taken % 80 == 0)
                rx_calm = ($urandom_range(0, 3) == 0);
            gap = rx_calm ? 0 : $urandom_range(0, MAX_WAIT);
            if (gap > 0)
            begin
                result_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_if.ready <= 1'b1;
            do @(posedge clk); while (!result_if.valid);
            taken++;
        end
    end

    always @(posedge clk)
    begin
        mag_result_t want;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (expected_q.size() == 0)
            begin
                $error("result transaction arrived with no result expected");
                mismatches++;
            end
            else
            begin
                want = expected_q.pop_front();
                check_field("kind", want.kind, result_if.kind);
                check_field("x_out", $signed(want.x_out), result_if.x_out);
                check_field("y_out", $signed(want.y_out), result_if.y_out);
                check_field("z_out", $signed(want.z_out), result_if.z_out);
                check_field("x_gain", want.x_gain, result_if.x_gain);
                check_field("y_gain", want.y_gain, result_if.y_gain);
                check_field("z_gain", want.z_gain, result_if.z_gain);
                check_field("span_error", want.span_error, result_if.span_error);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

endmodule
